// ===== sv/scaled_dither_mono_row_renderer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the row renderer
// Shared same-cycle-implication and next-cycle-implication checks.
// ----------------------------------------------------------------------------
`ifndef SCALED_DITHER_MONO_ROW_RENDERER_ASSERT_SVH
`define SCALED_DITHER_MONO_ROW_RENDERER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDMR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sdmr_pkg.sv =====
// ----------------------------------------------------------------------------
// sdmr_pkg
// Constants, types and the shade-to-colour function of the row renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package sdmr_pkg;

  // Store and screen geometry.
  localparam int SRC_PIXELS    = 32768;
  localparam int SCREEN_WIDTH  = 400;
  localparam int SCREEN_HEIGHT = 240;
  localparam int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8;
  localparam int FB_BYTES      = ROW_BYTES * SCREEN_HEIGHT;
  localparam int SRC_AW        = $clog2(SRC_PIXELS);
  localparam int FB_AW         = $clog2(FB_BYTES);

  // Signed screen positions, size registers, scaled products.
  localparam int PW     = 13;
  localparam int SZW    = 11;
  localparam int BW     = 2 * SZW;
  localparam int DIV_NW = 21;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  localparam logic signed [PW-1:0] SCREEN_W_S = PW'(SCREEN_WIDTH);
  localparam logic signed [PW-1:0] SCREEN_H_S = PW'(SCREEN_HEIGHT);

  // Bayer 2x2 thresholds and shade levels.
  localparam logic [2:0] DITHER_THRESH [4] = '{3'd0, 3'd2, 3'd3, 3'd1};
  localparam logic [2:0] SHADE_LEVEL   [4] = '{3'd0, 3'd1, 3'd3, 3'd4};

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_RENDER = 2'd1,
    CMD_READ   = 2'd2,
    CMD_WRITE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH   = 3'd0,
    REG_SRC_HEIGHT  = 3'd1,
    REG_DST_WIDTH   = 3'd2,
    REG_DST_HEIGHT  = 3'd3,
    REG_CLIP_LEFT   = 3'd4,
    REG_CLIP_TOP    = 3'd5,
    REG_CLIP_RIGHT  = 3'd6,
    REG_CLIP_BOTTOM = 3'd7
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FBRD,
    ST_DIV_SY,
    ST_DIV_SX,
    ST_DIV_STEP,
    ST_RUN,
    ST_DRAIN,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [SZW-1:0] src_width;
    logic [SZW-1:0] src_height;
    logic [SZW-1:0] dst_width;
    logic [SZW-1:0] dst_height;
    logic [8:0]     clip_left;
    logic [7:0]     clip_top;
    logic [8:0]     clip_right;
    logic [7:0]     clip_bottom;
  } cfg_t;

  // One classified command as it waits in the queue.
  typedef struct packed {
    cmd_e              cmd;
    logic              src_ok;
    logic [14:0]       src_addr;
    logic [1:0]        src_shade;
    logic [9:0]        dest_row;
    logic signed [9:0] origin_x;
    logic signed [9:0] origin_y;
    logic              dither_on;
    logic              invert_on;
    logic              fb_ok;
    logic [FB_AW-1:0]  fb_addr;
    logic [7:0]        fb_data;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } queue_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [SZW-1:0]    den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [SZW-1:0]    rem;
  } div_rsp_t;

  // Colour of one pixel: 1 means black.
  function automatic logic pixel_black(input logic [1:0] shade, input logic dith,
                                       input logic inv, input logic py0, input logic px0);
    logic [1:0] s;
    logic       blk;
    s = inv ? ~shade : shade;
    if (!dith || s == 2'd0 || s == 2'd3) begin
      blk = (s == 2'd3) || (!dith && s[1]);
    end else begin
      blk = DITHER_THRESH[{py0, px0}] < SHADE_LEVEL[s];
    end
    return blk;
  endfunction

endpackage

`default_nettype wire

// ===== sv/sdmr_in_if.sv =====
// ----------------------------------------------------------------------------
// sdmr_in_if
// Command channel: valid/ready handshake with the command fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdmr_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [14:0]       src_addr;
  logic [1:0]        src_shade;
  logic [9:0]        dest_row;
  logic signed [9:0] origin_x;
  logic signed [9:0] origin_y;
  logic              dither_on;
  logic              invert_on;
  logic [7:0]        fb_row;
  logic [5:0]        fb_byte;
  logic [7:0]        fb_data;

  modport source (output valid, command, src_addr, src_shade, dest_row, origin_x,
                  origin_y, dither_on, invert_on, fb_row, fb_byte, fb_data,
                  input ready);
  modport sink (input valid, command, src_addr, src_shade, dest_row, origin_x,
                origin_y, dither_on, invert_on, fb_row, fb_byte, fb_data,
                output ready);
endinterface

`default_nettype wire

// ===== sv/sdmr_out_if.sv =====
// ----------------------------------------------------------------------------
// sdmr_out_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdmr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       row_visible;
  logic       row_changed;

  modport source (output valid, read_data, row_visible, row_changed, input ready);
  modport sink (input valid, read_data, row_visible, row_changed, output ready);
endinterface

`default_nettype wire

// ===== sv/scaled_dither_mono_row_renderer.sv =====
// Commands are executed one at a time.
// The three divisions and the one-read-per-cycle source port set the render time.
// Reset clears the queue, the sequencer and the result register and loads the register defaults.
// The source and framebuffer stores are not cleared by reset.
// ----------------------------------------------------------------------------
// scaled_dither_mono_row_renderer
// Scaled, dithered monochrome row renderer with a command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_dither_mono_row_renderer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  sdmr_in_if.sink     in_ch,
  sdmr_out_if.source  out_ch
);

  sdmr_pkg::cfg_t   cfg_q;
  sdmr_pkg::queue_t head;
  logic             pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width   <= 11'd200;
      cfg_q.src_height  <= 11'd120;
      cfg_q.dst_width   <= 11'd400;
      cfg_q.dst_height  <= 11'd240;
      cfg_q.clip_left   <= 9'd0;
      cfg_q.clip_top    <= 8'd0;
      cfg_q.clip_right  <= 9'd400;
      cfg_q.clip_bottom <= 8'd240;
    end else if (cfg_we_i) begin
      unique case (sdmr_pkg::reg_e'(cfg_idx_i))
        sdmr_pkg::REG_SRC_WIDTH:   cfg_q.src_width   <= cfg_data_i;
        sdmr_pkg::REG_SRC_HEIGHT:  cfg_q.src_height  <= cfg_data_i;
        sdmr_pkg::REG_DST_WIDTH:   cfg_q.dst_width   <= cfg_data_i;
        sdmr_pkg::REG_DST_HEIGHT:  cfg_q.dst_height  <= cfg_data_i;
        sdmr_pkg::REG_CLIP_LEFT:   cfg_q.clip_left   <= cfg_data_i[8:0];
        sdmr_pkg::REG_CLIP_TOP:    cfg_q.clip_top    <= cfg_data_i[7:0];
        sdmr_pkg::REG_CLIP_RIGHT:  cfg_q.clip_right  <= cfg_data_i[8:0];
        sdmr_pkg::REG_CLIP_BOTTOM: cfg_q.clip_bottom <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  sdmr_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .pop_i(pop), .head_o(head)
  );

  sdmr_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_i(cfg_q), .head_i(head), .pop_o(pop),
    .out_ch(out_ch)
  );

endmodule

`default_nettype wire

// ===== sv/sdmr_ram.sv =====
// ----------------------------------------------------------------------------
// sdmr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sdmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/sdmr_div.sv =====
// ----------------------------------------------------------------------------
// sdmr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sdmr_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sdmr_pkg::div_req_t  req_i,
  output sdmr_pkg::div_rsp_t  rsp_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [sdmr_pkg::DIV_CW-1:0]       cnt_q;
  logic [sdmr_pkg::DIV_NW-1:0]       quo_q;
  logic [sdmr_pkg::SZW-1:0]          rem_q;
  logic [sdmr_pkg::SZW-1:0]          den_q;
  logic [sdmr_pkg::SZW:0]            rem_t;
  logic                              ge;
  logic [sdmr_pkg::SZW:0]            rem_sub;

  // Shift in the next numerator bit and try the subtraction.
  always_comb begin
    rem_t   = {rem_q, quo_q[sdmr_pkg::DIV_NW-1]};
    ge      = rem_t >= {1'b0, den_q};
    rem_sub = rem_t - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= sdmr_pkg::DIV_CW'(sdmr_pkg::DIV_NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == sdmr_pkg::DIV_CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath needs no reset.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.num;
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      quo_q <= {quo_q[sdmr_pkg::DIV_NW-2:0], ge};
      rem_q <= ge ? rem_sub[sdmr_pkg::SZW-1:0] : rem_t[sdmr_pkg::SZW-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

// ===== sv/sdmr_front.sv =====
// ----------------------------------------------------------------------------
// sdmr_front
// Accepts commands, checks and resolves their addresses, and queues them.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scaled_dither_mono_row_renderer_assert.svh"

module sdmr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  sdmr_in_if.sink             in_ch,
  input  logic                pop_i,
  output sdmr_pkg::queue_t    head_o
);

  sdmr_pkg::job_t ent_q [2];
  sdmr_pkg::job_t job_d;
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push;
  logic [31:0]    fb_lin;

  assign in_ch.ready = (cnt_q != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;

  // Classify the command and resolve the framebuffer byte address.
  always_comb begin
    fb_lin          = 32'(in_ch.fb_row) * 32'(sdmr_pkg::ROW_BYTES) + 32'(in_ch.fb_byte);
    job_d.cmd       = sdmr_pkg::cmd_e'(in_ch.command);
    job_d.src_ok    = 32'(in_ch.src_addr) < 32'(sdmr_pkg::SRC_PIXELS);
    job_d.src_addr  = in_ch.src_addr;
    job_d.src_shade = in_ch.src_shade;
    job_d.dest_row  = in_ch.dest_row;
    job_d.origin_x  = in_ch.origin_x;
    job_d.origin_y  = in_ch.origin_y;
    job_d.dither_on = in_ch.dither_on;
    job_d.invert_on = in_ch.invert_on;
    job_d.fb_ok     = (32'(in_ch.fb_row) < 32'(sdmr_pkg::SCREEN_HEIGHT)) &&
                      (32'(in_ch.fb_byte) < 32'(sdmr_pkg::ROW_BYTES));
    job_d.fb_addr   = fb_lin[sdmr_pkg::FB_AW-1:0];
    job_d.fb_data   = in_ch.fb_data;
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push && pop_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Queue entries.
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= job_d;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.job   = ent_q[rd_ptr_q];

  `SDMR_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= 2'd2, "queue count out of range")
  `SDMR_ASSERT_NOW(a_pop_nonempty, pop_i, cnt_q != 2'd0, "pop from an empty queue")
  `SDMR_ASSERT_NEXT(a_push_grow, push && !pop_i, cnt_q == $past(cnt_q) + 2'd1, "queue lost a beat")

endmodule

`default_nettype wire

// ===== sv/sdmr_back.sv =====
// ----------------------------------------------------------------------------
// sdmr_back
// Executes queued commands: store loads, framebuffer access and row render.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scaled_dither_mono_row_renderer_assert.svh"

module sdmr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sdmr_pkg::cfg_t     cfg_i,
  input  sdmr_pkg::queue_t   head_i,
  output logic               pop_o,
  sdmr_out_if.source         out_ch
);

  sdmr_pkg::state_e state_q, state_d;
  sdmr_pkg::job_t   job_q;
  sdmr_pkg::div_req_t div_req;
  sdmr_pkg::div_rsp_t div_rsp;

  // Render context.
  logic signed [sdmr_pkg::PW-1:0]  py_q, xs_q, xe_q, px_q;
  logic [sdmr_pkg::SZW-1:0]        sy_q, q0_q, r0_q, r_q;
  logic [sdmr_pkg::SZW:0]          sx_q;
  logic [sdmr_pkg::BW-1:0]         base_q;
  logic [sdmr_pkg::FB_AW-1:0]      row_base_q;
  logic                            first_q;

  // Pixel write-back stage.
  logic                            b_vld_q, b_new_q, b_end_q, b_zero_q;
  logic [2:0]                      b_bit_q;
  logic [sdmr_pkg::FB_AW-1:0]      b_baddr_q;
  logic [7:0]                      byte_q, orig_q;
  logic                            chg_q;

  // Pending and presented result.
  logic [7:0]                      pend_data_q, out_data_q;
  logic                            pend_vis_q, pend_chg_q;
  logic                            out_vld_q, out_vis_q, out_chg_q;

  // Memory ports.
  logic                            src_we, src_re, fb_we, fb_re;
  logic [sdmr_pkg::SRC_AW-1:0]     src_waddr, src_raddr;
  logic [sdmr_pkg::FB_AW-1:0]      fb_waddr, fb_raddr;
  logic [7:0]                      fb_wdata, fb_rdata;
  logic [1:0]                      src_rdata;

  // Combinational helpers.
  logic signed [sdmr_pkg::PW-1:0]  ox_s, py_c, ct_s, cb_s, cl_s, cr_s, dw_s, xs_c, xe_c, oxw;
  logic signed [sdmr_pkg::PW-1:0]  dx0_s;
  logic [sdmr_pkg::PW-1:0]         px_u, py_u;
  logic                            vis_c, load_res, start_run;
  logic [31:0]                     load_idx, row_lin, addr_w;
  logic [sdmr_pkg::BW:0]           addr_c;
  logic                            src_in_c, last_c, new_c, end_c, wrap_c;
  logic [sdmr_pkg::SZW:0]          r_sum;
  logic [1:0]                      shade_c;
  logic [7:0]                      mask_c, base_byte, orig_c, upd_c;
  logic                            chg_c;

  sdmr_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));

  sdmr_ram #(.WIDTH(2), .DEPTH(sdmr_pkg::SRC_PIXELS)) u_src_ram (
    .clk_i(clk_i), .we_i(src_we), .waddr_i(src_waddr), .wdata_i(job_q.src_shade),
    .re_i(src_re), .raddr_i(src_raddr), .rdata_o(src_rdata)
  );

  sdmr_ram #(.WIDTH(8), .DEPTH(sdmr_pkg::FB_BYTES)) u_fb_ram (
    .clk_i(clk_i), .we_i(fb_we), .waddr_i(fb_waddr), .wdata_i(fb_wdata),
    .re_i(fb_re), .raddr_i(fb_raddr), .rdata_o(fb_rdata)
  );

  // Row visibility and the horizontal span on screen.
  always_comb begin
    ox_s  = sdmr_pkg::PW'(job_q.origin_x);
    py_c  = sdmr_pkg::PW'(job_q.origin_y) + $signed({3'b000, job_q.dest_row});
    ct_s  = $signed({5'b00000, cfg_i.clip_top});
    cb_s  = $signed({5'b00000, cfg_i.clip_bottom});
    cl_s  = $signed({4'b0000, cfg_i.clip_left});
    cr_s  = $signed({4'b0000, cfg_i.clip_right});
    dw_s  = $signed({2'b00, cfg_i.dst_width});
    vis_c = (cfg_i.src_width != '0) && (cfg_i.src_height != '0) &&
            (cfg_i.dst_width != '0) && (cfg_i.dst_height != '0) &&
            ({1'b0, job_q.dest_row} < cfg_i.dst_height) &&
            (py_c >= ct_s) && (py_c < cb_s) && (py_c >= 0) && (py_c < sdmr_pkg::SCREEN_H_S);
    xs_c  = (cl_s > ox_s) ? cl_s : ox_s;
    oxw   = ox_s + dw_s;
    xe_c  = (cr_s < sdmr_pkg::SCREEN_W_S) ? cr_s : sdmr_pkg::SCREEN_W_S;
    if (oxw < xe_c) begin
      xe_c = oxw;
    end
    dx0_s = xs_q - ox_s;
    py_u  = py_q;
    row_lin = 32'(py_u) * 32'(sdmr_pkg::ROW_BYTES);
  end

  // Source address and column stepping for the current pixel.
  always_comb begin
    addr_c   = {1'b0, base_q} + (sdmr_pkg::BW + 1)'(sx_q);
    addr_w   = 32'(addr_c);
    src_in_c = addr_w < 32'(sdmr_pkg::SRC_PIXELS);
    r_sum    = {1'b0, r_q} + {1'b0, r0_q};
    wrap_c   = r_sum >= {1'b0, cfg_i.dst_width};
    last_c   = (px_q == xe_q - sdmr_pkg::PW'(1));
    px_u     = px_q;
    new_c    = first_q || (px_u[2:0] == 3'd0);
    end_c    = last_c || (px_u[2:0] == 3'd7);
    load_idx = 32'(job_q.src_addr);
  end

  // Pixel colour and byte update in the write-back stage.
  always_comb begin
    shade_c   = b_zero_q ? 2'd0 : src_rdata;
    mask_c    = 8'd1 << b_bit_q;
    base_byte = b_new_q ? fb_rdata : byte_q;
    orig_c    = b_new_q ? fb_rdata : orig_q;
    upd_c     = sdmr_pkg::pixel_black(shade_c, job_q.dither_on, job_q.invert_on, py_q[0],
                                      b_bit_q[0]) ? (base_byte & ~mask_c) : (base_byte | mask_c);
    chg_c     = chg_q || (b_vld_q && b_end_q && (upd_c != orig_c));
  end

  // Memory port steering.
  always_comb begin
    src_we    = (state_q == sdmr_pkg::ST_EXEC) && (job_q.cmd == sdmr_pkg::CMD_LOAD) &&
                job_q.src_ok;
    src_waddr = load_idx[sdmr_pkg::SRC_AW-1:0];
    src_re    = (state_q == sdmr_pkg::ST_RUN) && src_in_c;
    src_raddr = addr_w[sdmr_pkg::SRC_AW-1:0];
    if (state_q == sdmr_pkg::ST_EXEC) begin
      fb_we    = (job_q.cmd == sdmr_pkg::CMD_WRITE) && job_q.fb_ok;
      fb_waddr = job_q.fb_addr;
      fb_wdata = job_q.fb_data;
      fb_re    = (job_q.cmd == sdmr_pkg::CMD_READ) && job_q.fb_ok;
      fb_raddr = job_q.fb_addr;
    end else begin
      fb_we    = b_vld_q && b_end_q;
      fb_waddr = b_baddr_q;
      fb_wdata = upd_c;
      fb_re    = (state_q == sdmr_pkg::ST_RUN) && new_c;
      fb_raddr = row_base_q + sdmr_pkg::FB_AW'(px_u[sdmr_pkg::PW-1:3]);
    end
  end

  // Sequencer: next state, queue pop and divider requests.
  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    div_req     = '0;
    load_res    = 1'b0;
    start_run   = 1'b0;
    unique case (state_q)
      sdmr_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          state_d = sdmr_pkg::ST_EXEC;
        end
      end
      sdmr_pkg::ST_EXEC: begin
        unique case (job_q.cmd)
          sdmr_pkg::CMD_READ: begin
            state_d = job_q.fb_ok ? sdmr_pkg::ST_FBRD : sdmr_pkg::ST_RESP;
          end
          sdmr_pkg::CMD_RENDER: begin
            if (vis_c) begin
              div_req.start = 1'b1;
              div_req.num   = sdmr_pkg::DIV_NW'(job_q.dest_row) *
                              sdmr_pkg::DIV_NW'(cfg_i.src_height);
              div_req.den   = cfg_i.dst_height;
              state_d       = sdmr_pkg::ST_DIV_SY;
            end else begin
              state_d = sdmr_pkg::ST_RESP;
            end
          end
          default: begin
            state_d = sdmr_pkg::ST_RESP;
          end
        endcase
      end
      sdmr_pkg::ST_FBRD: begin
        state_d = sdmr_pkg::ST_RESP;
      end
      sdmr_pkg::ST_DIV_SY: begin
        if (div_rsp.done) begin
          if (xs_q < xe_q) begin
            div_req.start = 1'b1;
            div_req.num   = sdmr_pkg::DIV_NW'(dx0_s[9:0]) * sdmr_pkg::DIV_NW'(cfg_i.src_width);
            div_req.den   = cfg_i.dst_width;
            state_d       = sdmr_pkg::ST_DIV_SX;
          end else begin
            state_d = sdmr_pkg::ST_RESP;
          end
        end
      end
      sdmr_pkg::ST_DIV_SX: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = sdmr_pkg::DIV_NW'(cfg_i.src_width);
          div_req.den   = cfg_i.dst_width;
          state_d       = sdmr_pkg::ST_DIV_STEP;
        end
      end
      sdmr_pkg::ST_DIV_STEP: begin
        if (div_rsp.done) begin
          start_run = 1'b1;
          state_d   = sdmr_pkg::ST_RUN;
        end
      end
      sdmr_pkg::ST_RUN: begin
        if (last_c) begin
          state_d = sdmr_pkg::ST_DRAIN;
        end
      end
      sdmr_pkg::ST_DRAIN: begin
        state_d = sdmr_pkg::ST_RESP;
      end
      sdmr_pkg::ST_RESP: begin
        if (!out_vld_q || out_ch.ready) begin
          load_res = 1'b1;
          state_d  = sdmr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sdmr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sdmr_pkg::ST_IDLE;
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      b_vld_q <= (state_q == sdmr_pkg::ST_RUN);
      if (load_res) begin
        out_vld_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_i.job;
    end

    // Results default to zero until the command sets them.
    if (state_q == sdmr_pkg::ST_EXEC) begin
      pend_data_q <= 8'd0;
      pend_vis_q  <= 1'b0;
      pend_chg_q  <= 1'b0;
      py_q        <= py_c;
      xs_q        <= xs_c;
      xe_q        <= xe_c;
      chg_q       <= 1'b0;
    end else begin
      chg_q <= chg_c;
    end
    if (state_q == sdmr_pkg::ST_FBRD) begin
      pend_data_q <= fb_rdata;
    end

    if (state_q == sdmr_pkg::ST_DIV_SY) begin
      row_base_q <= row_lin[sdmr_pkg::FB_AW-1:0];
      if (div_rsp.done) begin
        sy_q       <= div_rsp.quot[sdmr_pkg::SZW-1:0];
        pend_vis_q <= 1'b1;
      end
    end
    if (state_q == sdmr_pkg::ST_DIV_SX) begin
      base_q <= sdmr_pkg::BW'(sy_q) * sdmr_pkg::BW'(cfg_i.src_width);
      if (div_rsp.done) begin
        sx_q <= div_rsp.quot[sdmr_pkg::SZW:0];
        r_q  <= div_rsp.rem;
      end
    end
    if (start_run) begin
      q0_q    <= div_rsp.quot[sdmr_pkg::SZW-1:0];
      r0_q    <= div_rsp.rem;
      px_q    <= xs_q;
      first_q <= 1'b1;
    end

    // One pixel issued per cycle.
    if (state_q == sdmr_pkg::ST_RUN) begin
      px_q      <= px_q + sdmr_pkg::PW'(1);
      first_q   <= 1'b0;
      r_q       <= wrap_c ? sdmr_pkg::SZW'(r_sum - {1'b0, cfg_i.dst_width})
                          : r_sum[sdmr_pkg::SZW-1:0];
      sx_q      <= sx_q + (sdmr_pkg::SZW + 1)'(q0_q) + (sdmr_pkg::SZW + 1)'(wrap_c);
      b_bit_q   <= px_u[2:0];
      b_new_q   <= new_c;
      b_end_q   <= end_c;
      b_zero_q  <= !src_in_c;
      b_baddr_q <= fb_raddr;
    end
    if (b_vld_q) begin
      byte_q <= upd_c;
      orig_q <= orig_c;
    end
    if (state_q == sdmr_pkg::ST_DRAIN) begin
      pend_chg_q <= chg_c;
    end

    if (load_res) begin
      out_data_q <= pend_data_q;
      out_vis_q  <= pend_vis_q;
      out_chg_q  <= pend_chg_q;
    end
  end

  assign out_ch.valid       = out_vld_q;
  assign out_ch.read_data   = out_data_q;
  assign out_ch.row_visible = out_vis_q;
  assign out_ch.row_changed = out_chg_q;

  `SDMR_ASSERT_NOW(a_run_span, state_q == sdmr_pkg::ST_RUN, px_q < xe_q, "pixel past the span")
  `SDMR_ASSERT_NOW(a_rem_range, state_q == sdmr_pkg::ST_RUN, r_q < cfg_i.dst_width, "step remainder too big")
  `SDMR_ASSERT_NOW(a_chg_vis, out_vld_q, !out_chg_q || out_vis_q, "changed row not visible")
  `SDMR_ASSERT_NEXT(a_pop_exec, pop_o, state_q == sdmr_pkg::ST_EXEC, "popped command not executed")

endmodule

`default_nettype wire

// ===== sim/scaled_dither_mono_row_renderer_tb.sv =====
// ----------------------------------------------------------------------------
// scaled_dither_mono_row_renderer_tb
// Self-checking bench for the row renderer. It fills both stores, runs a few
// directed commands, then random beats under several register settings. A
// scoreboard predicts every result from its own copy of the stores and the
// registers, and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_dither_mono_row_renderer_tb;
  import sdmr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int HOLD_CYCLES     = 300;
  localparam int PHASE_BEATS     = 67;

  typedef struct {
    cmd_e              cmd;
    logic [14:0]       src_addr;
    logic [1:0]        src_shade;
    logic [9:0]        dest_row;
    logic signed [9:0] origin_x;
    logic signed [9:0] origin_y;
    logic              dither_on;
    logic              invert_on;
    logic [7:0]        fb_row;
    logic [5:0]        fb_byte;
    logic [7:0]        fb_data;
  } cmd_beat_t;

  typedef struct {
    logic [7:0] read_data;
    logic       row_visible;
    logic       row_changed;
  } result_t;

  // Scoreboard: own copy of both stores and the registers.
  class frame_scoreboard;
    logic [1:0]  shades [SRC_PIXELS];
    logic [7:0]  frame [FB_BYTES];
    int unsigned regs [8];
    int unsigned bayer [4] = '{0, 2, 3, 1};
    int unsigned level [4] = '{0, 1, 3, 4};
    result_t     pending_results [$];
    int          failures;

    function new();
      regs = '{200, 120, 400, 240, 0, 0, 400, 240};
      failures = 0;
    endfunction

    function void set_reg(reg_e r, int unsigned v);
      int unsigned masks [8];
      masks = '{'h7FF, 'h7FF, 'h7FF, 'h7FF, 'h1FF, 'hFF, 'h1FF, 'hFF};
      regs[r] = v & masks[r];
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Draws one destination row into the frame copy and reports the outcome.
    function result_t draw_row(cmd_beat_t b);
      int          py, px, xhi, dx;
      int unsigned sy, sx, base, idx;
      logic [7:0]  line [ROW_BYTES];
      logic [1:0]  s;
      logic        blk;
      logic        differs;
      result_t     r;
      r = '{8'd0, 1'b0, 1'b0};
      if (regs[REG_SRC_WIDTH] == 0 || regs[REG_SRC_HEIGHT] == 0 ||
          regs[REG_DST_WIDTH] == 0 || regs[REG_DST_HEIGHT] == 0) return r;
      if (b.dest_row >= regs[REG_DST_HEIGHT]) return r;
      py = int'(b.origin_y) + int'(b.dest_row);
      if (py < int'(regs[REG_CLIP_TOP]) || py >= int'(regs[REG_CLIP_BOTTOM]) ||
          py < 0 || py >= SCREEN_HEIGHT) return r;
      sy = b.dest_row * regs[REG_SRC_HEIGHT] / regs[REG_DST_HEIGHT];
      base = sy * regs[REG_SRC_WIDTH];
      for (int i = 0; i < ROW_BYTES; i++) line[i] = frame[py * ROW_BYTES + i];
      xhi = int'(regs[REG_CLIP_RIGHT]);
      if (xhi > SCREEN_WIDTH) xhi = SCREEN_WIDTH;
      for (px = int'(regs[REG_CLIP_LEFT]); px < xhi; px++) begin
        dx = px - int'(b.origin_x);
        if (dx < 0 || dx >= int'(regs[REG_DST_WIDTH])) continue;
        sx = dx * regs[REG_SRC_WIDTH] / regs[REG_DST_WIDTH];
        idx = base + sx;
        s = (idx < SRC_PIXELS) ? shades[idx] : 2'd0;
        if (b.invert_on) s = 2'd3 - s;
        if (!b.dither_on || s == 2'd0 || s == 2'd3) begin
          blk = (s == 2'd3) || (!b.dither_on && s >= 2'd2);
        end else begin
          blk = bayer[(py & 1) * 2 + (px & 1)] < level[s];
        end
        line[px / 8][px % 8] = !blk;
      end
      r.row_visible = 1'b1;
      differs = 1'b0;
      for (int i = 0; i < ROW_BYTES; i++) begin
        if (line[i] != frame[py * ROW_BYTES + i]) differs = 1'b1;
        frame[py * ROW_BYTES + i] = line[i];
      end
      r.row_changed = differs;
      return r;
    endfunction

    // Notes an accepted command beat and queues the result it must cause.
    function void accept(cmd_beat_t b);
      result_t r;
      logic    fb_ok;
      r = '{8'd0, 1'b0, 1'b0};
      fb_ok = b.fb_row < SCREEN_HEIGHT && b.fb_byte < ROW_BYTES;
      case (b.cmd)
        CMD_LOAD: begin
          if (b.src_addr < SRC_PIXELS) shades[b.src_addr] = b.src_shade;
        end
        CMD_RENDER: begin
          r = draw_row(b);
        end
        CMD_READ: begin
          if (fb_ok) r.read_data = frame[b.fb_row * ROW_BYTES + b.fb_byte];
        end
        default: begin
          if (fb_ok) frame[b.fb_row * ROW_BYTES + b.fb_byte] = b.fb_data;
        end
      endcase
      pending_results.push_back(r);
    endfunction

    // Compares one result beat with the oldest prediction.
    function void check(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10) $display("Result beat with nothing expected: rd=%0h vis=%0b chg=%0b",
                                     got.read_data, got.row_visible, got.row_changed);
        return;
      end
      want = pending_results.pop_front();
      if (got.read_data !== want.read_data || got.row_visible !== want.row_visible ||
          got.row_changed !== want.row_changed) begin
        failures++;
        if (failures <= 10) $display("Mismatch: expected rd=%0h vis=%0b chg=%0b, got rd=%0h vis=%0b chg=%0b",
                                     want.read_data, want.row_visible, want.row_changed,
                                     got.read_data, got.row_visible, got.row_changed);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [10:0] cfg_data_i;

  sdmr_in_if  in_ch ();
  sdmr_out_if out_ch ();

  scaled_dither_mono_row_renderer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch.sink),
    .out_ch     (out_ch.source)
  );

  frame_scoreboard sb = new();
  bit gaps_on   = 1'b0;
  bit hold_sink = 1'b0;
  bit beat_seen = 1'b0;
  int idle_cycles = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Result side: random back-pressure, plus one long hold on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_sink = 1'b0;
      end else begin
        out_ch.ready <= !(gaps_on && $urandom_range(99) < 33);
      end
    end
  end

  // Result beats are sampled mid-cycle and take effect at the next edge.
  always @(negedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      beat_seen = 1'b1;
      sb.check('{out_ch.read_data, out_ch.row_visible, out_ch.row_changed});
    end
  end

  // Watchdog on cycles without any beat.
  always @(posedge clk_i) begin
    if (beat_seen || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    beat_seen = 1'b0;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send(input cmd_beat_t b);
    while (gaps_on && $urandom_range(99) < 33) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.command   <= b.cmd;
    in_ch.src_addr  <= b.src_addr;
    in_ch.src_shade <= b.src_shade;
    in_ch.dest_row  <= b.dest_row;
    in_ch.origin_x  <= b.origin_x;
    in_ch.origin_y  <= b.origin_y;
    in_ch.dither_on <= b.dither_on;
    in_ch.invert_on <= b.invert_on;
    in_ch.fb_row    <= b.fb_row;
    in_ch.fb_byte   <= b.fb_byte;
    in_ch.fb_data   <= b.fb_data;
    in_ch.valid     <= 1'b1;
    do @(negedge clk_i); while (!in_ch.ready);
    sb.accept(b);
    beat_seen = 1'b1;
    @(posedge clk_i);
  endtask

  // Stops offering beats until every predicted result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic program_regs(input int unsigned v [8]);
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= reg_e'(i);
      cfg_data_i <= v[i];
      @(posedge clk_i);
      sb.set_reg(reg_e'(i), v[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic cmd_beat_t blank_beat(cmd_e c);
    cmd_beat_t b;
    b = '{c, 15'd0, 2'd0, 10'd0, 10'sd0, 10'sd0, 1'b0, 1'b0, 8'd0, 6'd0, 8'd0};
    return b;
  endfunction

  function automatic cmd_beat_t render_beat(int row, int ox, int oy, bit d, bit v);
    cmd_beat_t b;
    b = blank_beat(CMD_RENDER);
    b.dest_row  = row;
    b.origin_x  = ox;
    b.origin_y  = oy;
    b.dither_on = d;
    b.invert_on = v;
    return b;
  endfunction

  // Random beat: every field random, most renders steered toward rows near the screen.
  function automatic cmd_beat_t random_beat();
    cmd_beat_t   b;
    int unsigned pick, rows;
    int          target, oy;
    pick = $urandom_range(99);
    b.cmd       = pick < 50 ? CMD_RENDER : pick < 70 ? CMD_LOAD : pick < 85 ? CMD_READ : CMD_WRITE;
    b.src_addr  = $urandom;
    b.src_shade = $urandom;
    b.dest_row  = $urandom;
    b.origin_x  = $urandom;
    b.origin_y  = $urandom;
    b.dither_on = $urandom;
    b.invert_on = $urandom;
    b.fb_row    = $urandom;
    b.fb_byte   = $urandom;
    b.fb_data   = $urandom;
    if (b.cmd != CMD_RENDER && $urandom_range(3) != 0) begin
      b.fb_row  = $urandom_range(SCREEN_HEIGHT - 1);
      b.fb_byte = $urandom_range(ROW_BYTES - 1);
    end
    if (b.cmd == CMD_RENDER && $urandom_range(7) != 0) begin
      rows = sb.regs[REG_DST_HEIGHT];
      if (rows > 1024) rows = 1024;
      if (rows > 0) b.dest_row = $urandom_range(rows - 1);
      target = int'($urandom_range(259)) - 10;
      oy = target - int'(b.dest_row);
      if (oy >= -512 && oy <= 511) b.origin_y = oy;
      b.origin_x = int'($urandom_range(150)) - 50;
    end
    return b;
  endfunction

  initial begin
    cmd_beat_t   b;
    int unsigned settings [6][8];
    settings = '{
      '{200, 120, 400, 240, 0, 0, 400, 240},
      '{1024, 1024, 1, 1, 0, 0, 400, 240},
      '{1, 1, 1024, 2047, 400, 240, 0, 0},
      '{37, 23, 150, 90, 13, 7, 311, 201},
      '{0, 2047, 400, 240, 511, 255, 400, 240},
      '{2047, 100, 2047, 200, 1, 1, 511, 255}
    };

    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_SRC_WIDTH;
    cfg_data_i = 11'd0;
    in_ch.valid = 1'b0;
    b = blank_beat(CMD_LOAD);
    in_ch.command   = b.cmd;
    in_ch.src_addr  = '0;
    in_ch.src_shade = '0;
    in_ch.dest_row  = '0;
    in_ch.origin_x  = '0;
    in_ch.origin_y  = '0;
    in_ch.dither_on = 1'b0;
    in_ch.invert_on = 1'b0;
    in_ch.fb_row    = '0;
    in_ch.fb_byte   = '0;
    in_ch.fb_data   = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill both stores so that no render ever reads an unwritten entry.
    for (int a = 0; a < SRC_PIXELS; a++) begin
      b = blank_beat(CMD_LOAD);
      b.src_addr  = a;
      b.src_shade = $urandom;
      send(b);
    end
    for (int r = 0; r < SCREEN_HEIGHT; r++) begin
      for (int c = 0; c < ROW_BYTES; c++) begin
        b = blank_beat(CMD_WRITE);
        b.fb_row  = r;
        b.fb_byte = c;
        b.fb_data = $urandom;
        send(b);
      end
    end

    // Directed beats at reset settings: store edges, bad addresses, all modes.
    gaps_on = 1'b1;
    b = blank_beat(CMD_LOAD);  b.src_addr = 15'h7FFF; b.src_shade = 2'd3; send(b);
    b = blank_beat(CMD_WRITE); b.fb_row = 8'hFF; b.fb_byte = 6'h3F; b.fb_data = 8'hFF; send(b);
    b = blank_beat(CMD_READ);  b.fb_row = 8'hFF; b.fb_byte = 6'h3F; send(b);
    b = blank_beat(CMD_WRITE); b.fb_row = 8'd239; b.fb_byte = 6'd49; b.fb_data = 8'h00; send(b);
    b = blank_beat(CMD_READ);  b.fb_row = 8'd239; b.fb_byte = 6'd49; send(b);
    b = blank_beat(CMD_READ);  b.fb_row = 8'd10; b.fb_byte = 6'd50; send(b);
    for (int m = 0; m < 4; m++) send(render_beat(m, 0, 0, m[0], m[1]));
    for (int m = 0; m < 4; m++) send(render_beat(239 - m, 0, 0, m[0], m[1]));
    send(render_beat(1023, 0, 0, 1, 0));
    send(render_beat(5, -512, 0, 1, 1));
    send(render_beat(5, 511, 3, 0, 1));
    send(render_beat(0, -100, -512, 1, 0));
    send(render_beat(239, 0, 511, 0, 0));
    send(render_beat(100, 37, -90, 1, 1));
    send(render_beat(7, 0, 0, 0, 0));

    // Random phases, each under its own register setting.
    for (int p = 0; p < 6; p++) begin
      program_regs(settings[p]);
      gaps_on = (p != 0);
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if (p == 3 && k == 20) hold_sink = 1'b1;
        if (p == 1 && k == 30) drain();
        send(random_beat());
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
